// File: design/trp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and constants of the tile pixel renderer.
// ----------------------------------------------------------------------------
package trp_pkg;

   // sizes
   localparam int VISIBLE_LINES   = 224;
   localparam int VISIBLE_COLUMNS = 240;
   localparam int VRAM_BYTES      = 2048;
   localparam int ROM_BYTES       = 65536;

   localparam int VRAM_AW         = $clog2(VRAM_BYTES);
   localparam int ROM_AW          = $clog2(ROM_BYTES);
   localparam int PLANES          = 3;
   localparam int VRAM_PLANE_AW   = VRAM_AW - 2;
   localparam int ROM_PLANE_AW    = ROM_AW - 2;
   localparam int VRAM_PLANE_DEPTH = VRAM_BYTES / 4;
   localparam int ROM_PLANE_DEPTH  = ROM_BYTES / 4;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

   // tile selection
   localparam logic [7:0] NAME_ROM_LIMIT = 8'hE0;
   localparam int         FORCE_ROM_BIT  = 4;
   localparam logic [7:0] RAM_SEL_OR     = 8'h03;

   // configuration register indexes
   localparam int         CSR_INDEX_W       = 2;
   localparam logic [1:0] CSR_ROM_TILE_BASE = 2'd0;
   localparam logic [1:0] CSR_RAM_TILE_BASE = 2'd1;

   typedef enum logic [1:0] {
      MODE_VRAM_WR = 2'd0,
      MODE_ROM_WR  = 2'd1,
      MODE_RENDER  = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type             kind;
      logic [15:0]          address;
      logic [7:0]           data;
      logic [7:0]           line;
      logic [7:0]           column;
      logic                 visible;
      logic [VRAM_AW-1:0]   name_addr;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [7:0] rom_tile_base;
      logic [7:0] ram_tile_base;
   } cfg_type;

endpackage
`default_nettype wire

// File: design/trp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_if
// Valid/ready channels of the tile pixel renderer.
// ----------------------------------------------------------------------------
interface trp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] address;
   logic [7:0]  data;
   logic [7:0]  line;
   logic [7:0]  column;

   modport source (output valid, mode, address, data, line, column, input ready);
   modport sink   (input valid, mode, address, data, line, column, output ready);
endinterface

interface trp_rsp_if;
   logic       valid;
   logic       ready;
   logic       red;
   logic       green;
   logic       blue;
   logic [7:0] pixel_line;
   logic [7:0] pixel_column;

   modport source (output valid, red, green, blue, pixel_line, pixel_column, input ready);
   modport sink   (input valid, red, green, blue, pixel_line, pixel_column, output ready);
endinterface

interface trp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [trp_pkg::CSR_INDEX_W-1:0] index;
   logic [7:0]                     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// File: design/tile_pixel_renderer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_pixel_renderer_top
// Character-tile pixel renderer with its own video RAM and pattern ROM.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus : one transfer per item. mode 0 writes video RAM (low 11 address
//             bits), mode 1 writes the pattern ROM, mode 2 renders the pixel
//             at line/column. Mode 3 is taken and dropped.
//   rsp_bus : one transfer per render: red/green/blue plane bits plus the
//             echoed line and column. Writes give no transfer.
//   csr_bus : register 0 rom_tile_base, register 1 ram_tile_base; always
//             ready, other indexes ignored. Write only while idle.
// Timing:
//   One item per clock sustained while rsp_bus takes results. A render
//   passes from the front register through the queue, name read, pattern
//   read and result register to rsp_bus. The two chained memory reads each
//   use a port of their own (name copy of VRAM, then one ROM bank and one
//   VRAM bank per color plane).
// Reset:
//   Clears the pipeline, queue and both registers. Memory contents are not
//   cleared; no clearing pass, the block is ready right after reset.
// Stall:
//   When rsp_bus stalls the back end holds; the 4-entry queue and the
//   front register keep taking transfers until they fill up.
// ----------------------------------------------------------------------------
module tile_pixel_renderer_top (
   input  logic       clock,
   input  logic       reset,
   trp_req_if.sink    req_bus,
   trp_rsp_if.source  rsp_bus,
   trp_csr_if.sink    csr_bus
);
   import trp_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   item_type  push_item;
   item_type  head_item;
   qstat_type qstat;
   logic      push;
   logic      pop;

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ROM_TILE_BASE: cfg_in.rom_tile_base = csr_bus.wdata;
            CSR_RAM_TILE_BASE: cfg_in.ram_tile_base = csr_bus.wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   trp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   // decoupling queue
   trp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // back: writes, lookups, result
   trp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_item (head_item),
      .qstat     (qstat),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule
`default_nettype wire

// File: design/trp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_front
// Accepts request transfers, drops unused modes, precomputes the name address.
// ----------------------------------------------------------------------------
module trp_front (
   input  logic                clock,
   input  logic                reset,
   trp_req_if.sink             req,
   input  trp_pkg::qstat_type  qstat,
   output logic                push,
   output trp_pkg::item_type   push_item
);
   import trp_pkg::*;

   logic     front_valid_ff, front_valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic     keep;

   assign req.ready = !front_valid_ff || !qstat.full;
   assign accept    = req.valid && req.ready;
   assign push      = front_valid_ff && !qstat.full;
   assign push_item = item_ff;

   always_comb begin
      unique case (req.mode)
         MODE_VRAM_WR, MODE_ROM_WR, MODE_RENDER: keep = 1'b1;
         default:                                 keep = 1'b0;
      endcase
      item_in.kind      = mode_type'(req.mode);
      item_in.address   = req.address;
      item_in.data      = req.data;
      item_in.line      = req.line;
      item_in.column    = req.column;
      item_in.visible   = ({1'b0, req.line} < 9'(VISIBLE_LINES)) &&
                          ({1'b0, req.column} < 9'(VISIBLE_COLUMNS));
      // 2 + column/8 + (line/8)*32
      item_in.name_addr = VRAM_AW'(12'd2 + 12'(req.column[7:3]) +
                                  12'({req.line[7:3], 5'b0}));
   end

   always_comb begin
      if (accept && keep) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// File: design/trp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module trp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  trp_pkg::item_type   push_item,
   input  logic                pop,
   output trp_pkg::item_type   head_item,
   output trp_pkg::qstat_type  qstat
);
   import trp_pkg::*;

   item_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;

   assign qstat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// File: design/trp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_back
// Executes writes, looks up name and pattern bytes, drives the result channel.
// ----------------------------------------------------------------------------
module trp_back (
   input  logic                clock,
   input  logic                reset,
   input  trp_pkg::cfg_type    cfg,
   input  trp_pkg::item_type   head_item,
   input  trp_pkg::qstat_type  qstat,
   output logic                pop,
   trp_rsp_if.source           rsp
);
   import trp_pkg::*;

   // name copy of video RAM, full size
   logic [7:0] vram_name [VRAM_BYTES];

   logic       en;
   logic       vram_wr, rom_wr;

   // stage 1: name byte
   logic       s1_valid_ff;
   logic [7:0] s1_line_ff, s1_column_ff;
   logic       s1_visible_ff;
   logic [7:0] name_ff;

   // stage 2: pattern bytes
   logic       s2_valid_ff;
   logic [7:0] s2_line_ff, s2_column_ff;
   logic       s2_visible_ff;
   logic       s2_use_rom_ff;
   logic [7:0] rom_rd_ff [PLANES];
   logic [7:0] ram_rd_ff [PLANES];

   // stage 3: result register
   logic       s3_valid_ff;
   logic       s3_red_ff, s3_green_ff, s3_blue_ff;
   logic [7:0] s3_line_ff, s3_column_ff;

   logic                     use_rom;
   logic [15:0]              rom_base;
   logic [7:0]               ram_sel;
   logic [VRAM_AW-1:0]       ram_base;
   logic [ROM_PLANE_AW-1:0]  rom_rd_idx;
   logic [VRAM_PLANE_AW-1:0] ram_rd_idx;
   logic [ROM_PLANE_AW-1:0]  rom_wr_idx;
   logic [VRAM_PLANE_AW-1:0] ram_wr_idx;
   logic [PLANES-1:0]        pix;

   assign en      = !s3_valid_ff || rsp.ready;
   assign pop     = en && !qstat.empty;
   assign vram_wr = pop && (head_item.kind == MODE_VRAM_WR);
   assign rom_wr  = pop && (head_item.kind == MODE_ROM_WR);

   assign rom_wr_idx = {head_item.address[ROM_AW-1:5], head_item.address[2:0]};
   assign ram_wr_idx = {head_item.address[VRAM_AW-1:5], head_item.address[2:0]};

   // pattern addresses; tile bases are 32-byte aligned so the plane offset
   // only fills bits 4..0
   always_comb begin
      use_rom    = (name_ff < NAME_ROM_LIMIT) || cfg.rom_tile_base[FORCE_ROM_BIT];
      rom_base   = 16'({cfg.rom_tile_base[7:5], 13'b0}) + 16'({name_ff, 5'b0});
      ram_sel    = (cfg.ram_tile_base >> 2) | RAM_SEL_OR;
      ram_base   = VRAM_AW'({ram_sel, 10'b0}) + VRAM_AW'({name_ff[4:0], 5'b0});
      rom_rd_idx = {rom_base[ROM_AW-1:5], s1_line_ff[2:0]};
      ram_rd_idx = {ram_base[VRAM_AW-1:5], s1_line_ff[2:0]};
   end

   always_ff @(posedge clock) begin
      if (vram_wr) begin
         vram_name[head_item.address[VRAM_AW-1:0]] <= head_item.data;
      end
      if (en) begin
         name_ff <= vram_name[head_item.name_addr];
      end
   end

   // one ROM bank and one VRAM bank per color plane (offsets 8, 16, 24)
   for (genvar p = 0; p < PLANES; p++) begin : g_plane
      localparam logic [1:0] PLANE_CODE = 2'(p + 1);
      logic [7:0] rom_mem [ROM_PLANE_DEPTH];
      logic [7:0] ram_mem [VRAM_PLANE_DEPTH];

      always_ff @(posedge clock) begin
         if (rom_wr && (head_item.address[4:3] == PLANE_CODE)) begin
            rom_mem[rom_wr_idx] <= head_item.data;
         end
         if (en) begin
            rom_rd_ff[p] <= rom_mem[rom_rd_idx];
         end
      end

      always_ff @(posedge clock) begin
         if (vram_wr && (head_item.address[4:3] == PLANE_CODE)) begin
            ram_mem[ram_wr_idx] <= head_item.data;
         end
         if (en) begin
            ram_rd_ff[p] <= ram_mem[ram_rd_idx];
         end
      end

      // MSB-first bit pick
      assign pix[p] = s2_visible_ff &
                      (s2_use_rom_ff ? rom_rd_ff[p][~s2_column_ff[2:0]]
                                     : ram_rd_ff[p][~s2_column_ff[2:0]]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= pop && (head_item.kind == MODE_RENDER);
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_line_ff    <= head_item.line;
         s1_column_ff  <= head_item.column;
         s1_visible_ff <= head_item.visible;
         s2_line_ff    <= s1_line_ff;
         s2_column_ff  <= s1_column_ff;
         s2_visible_ff <= s1_visible_ff;
         s2_use_rom_ff <= use_rom;
         s3_red_ff     <= pix[0];
         s3_green_ff   <= pix[1];
         s3_blue_ff    <= pix[2];
         s3_line_ff    <= s2_line_ff;
         s3_column_ff  <= s2_column_ff;
      end
   end

   assign rsp.valid        = s3_valid_ff;
   assign rsp.red          = s3_red_ff;
   assign rsp.green        = s3_green_ff;
   assign rsp.blue         = s3_blue_ff;
   assign rsp.pixel_line   = s3_line_ff;
   assign rsp.pixel_column = s3_column_ff;

endmodule
`default_nettype wire

// File: tb/trp_render_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_render_check
// Pixel predictor and result comparison for the tile pixel renderer.
// Keeps its own video RAM, pattern ROM and tile base registers, updated from
// the accepted transfers. Queues the pixel that each render should produce
// and compares every result transfer with the oldest queued pixel.
// ----------------------------------------------------------------------------
module trp_render_check
   import trp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   trp_req_if   req_mon,
   trp_rsp_if   rsp_mon,
   trp_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);

   localparam int ROM_BANK_BYTES = 'h2000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic       red;
      logic       green;
      logic       blue;
      logic [7:0] line;
      logic [7:0] column;
   } pixel_type;

   logic [7:0] vram_image [VRAM_BYTES];
   logic [7:0] rom_image  [ROM_BYTES];
   cfg_type    tile_cfg;
   pixel_type  expected_pixels [$];
   int         errors   = 0;
   int         reported = 0;

   // one byte of a color plane of the tile selected by name
   function automatic logic [7:0] plane_byte(input logic [7:0] name, input int offset);
      logic [ROM_AW-1:0]  rom_addr;
      logic [VRAM_AW-1:0] ram_addr;
      logic [7:0]         ram_sel;
      if (name < NAME_ROM_LIMIT || tile_cfg.rom_tile_base[FORCE_ROM_BIT]) begin
         rom_addr = ROM_AW'(int'(tile_cfg.rom_tile_base[7:5]) * ROM_BANK_BYTES
                            + int'(name) * 32 + offset);
         return rom_image[rom_addr];
      end
      ram_sel  = (tile_cfg.ram_tile_base >> 2) | RAM_SEL_OR;
      ram_addr = VRAM_AW'((int'(ram_sel) << 10) + int'(name[4:0]) * 32 + offset);
      return vram_image[ram_addr];
   endfunction

   function automatic pixel_type predict_pixel(input logic [7:0] ln, input logic [7:0] cl);
      pixel_type  px;
      logic [7:0] name;
      logic [7:0] red_byte;
      logic [7:0] green_byte;
      logic [7:0] blue_byte;
      logic [2:0] pos;
      int         row;
      px        = '0;
      px.line   = ln;
      px.column = cl;
      // off-screen pixels come back black
      if (ln < VISIBLE_LINES && cl < VISIBLE_COLUMNS) begin
         name       = vram_image[VRAM_AW'(2 + cl / 8 + (ln / 8) * 32)];
         row        = int'(ln[2:0]);
         pos        = 3'd7 - cl[2:0];
         red_byte   = plane_byte(name, 8 + row);
         green_byte = plane_byte(name, 16 + row);
         blue_byte  = plane_byte(name, 24 + row);
         px.red     = red_byte[pos];
         px.green   = green_byte[pos];
         px.blue    = blue_byte[pos];
      end
      return px;
   endfunction

   function automatic void note_failure(input string msg);
      errors++;
      if (reported < MAX_REPORTS) begin
         reported++;
         $display("[%0t] %s", $realtime, msg);
      end
   endfunction

   always @(posedge clock) begin : monitor
      pixel_type got;
      pixel_type want;
      if (reset) begin
         tile_cfg = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.red    = rsp_mon.red;
            got.green  = rsp_mon.green;
            got.blue   = rsp_mon.blue;
            got.line   = rsp_mon.pixel_line;
            got.column = rsp_mon.pixel_column;
            if (expected_pixels.size() == 0) begin
               note_failure($sformatf("unexpected pixel rgb=%b%b%b at line %0d column %0d",
                                      got.red, got.green, got.blue, got.line, got.column));
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.line !== want.line ||
                   got.column !== want.column) begin
                  note_failure($sformatf({"pixel mismatch: expected rgb=%b%b%b ln %0d col %0d,",
                                          " got rgb=%b%b%b ln %0d col %0d"},
                                         want.red, want.green, want.blue, want.line,
                                         want.column, got.red, got.green, got.blue,
                                         got.line, got.column));
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ROM_TILE_BASE: tile_cfg.rom_tile_base = csr_mon.wdata;
               CSR_RAM_TILE_BASE: tile_cfg.ram_tile_base = csr_mon.wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.mode)
               MODE_VRAM_WR: vram_image[req_mon.address[VRAM_AW-1:0]] = req_mon.data;
               MODE_ROM_WR:  rom_image[req_mon.address[ROM_AW-1:0]]   = req_mon.data;
               MODE_RENDER:  expected_pixels.push_back(predict_pixel(req_mon.line,
                                                                     req_mon.column));
               default: ;
            endcase
         end
      end
      pending    <= expected_pixels.size();
      fail_count <= errors;
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tile pixel renderer.
// Writes tile names and pattern bytes, then renders pixels on top of them,
// under a series of tile base settings. Both handshake sides idle at random.
// The render checker next to the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_top;
   import trp_pkg::*;

   // mode 3 is taken by the block and dropped
   localparam logic [1:0]             MODE_UNUSED      = 2'd3;
   // index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int                     ROM_BANK_BYTES   = 'h2000;
   localparam int                     PHASE_ITEMS      = 250;
   localparam int                     RANDOM_PHASES    = 6;

   logic clock;
   logic reset;

   trp_req_if req_bus ();
   trp_rsp_if rsp_bus ();
   trp_csr_if csr_bus ();

   int pending_pixels;
   int mismatches;

   // items of modes 0..2 moved so far; dropped mode 3 items are not counted
   int items_sent = 0;
   // stretch of back-to-back transfers on the request side
   int burst_left = 0;

   // stimulus-side view of the tile bases and of which bytes hold data, so
   // that no render ever reads a byte that was never written
   logic [7:0] rom_base_now = '0;
   logic [7:0] ram_base_now = '0;
   logic [7:0] vram_shadow  [VRAM_BYTES];
   bit         vram_written [VRAM_BYTES];
   bit         rom_written  [ROM_BYTES];

   tile_pixel_renderer_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   trp_render_check render_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .fail_count (mismatches),
      .pending    (pending_pixels)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop, well past the slowest legal run
   initial begin
      #(10_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   // Request-side idle time: mostly none or short, now and then long, with
   // bursts of back-to-back transfers.
   function automatic int idle_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // tile names: both pattern sources, with the edges of each weighted up
   function automatic logic [7:0] pick_name();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 8'($urandom_range(0, NAME_ROM_LIMIT - 1));
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return NAME_ROM_LIMIT - 8'd1;
            2:       return NAME_ROM_LIMIT;
            default: return 8'hFF;
         endcase
      end
      return 8'($urandom_range(NAME_ROM_LIMIT, 255));
   endfunction

   function automatic logic [7:0] pick_line();
      if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, VISIBLE_LINES - 1));
      return 8'($urandom_range(VISIBLE_LINES, 255));
   endfunction

   // where a pattern byte of a tile lives under the current tile bases
   function automatic void pattern_source(input logic [7:0] nm, input int offset,
                                          output bit from_rom, output logic [15:0] addr);
      from_rom = nm < NAME_ROM_LIMIT || rom_base_now[FORCE_ROM_BIT];
      if (from_rom)
         addr = 16'(int'(rom_base_now[7:5]) * ROM_BANK_BYTES + int'(nm) * 32 + offset);
      else
         addr = 16'(((int'((ram_base_now >> 2) | RAM_SEL_OR) << 10) + int'(nm[4:0]) * 32
                     + offset) % VRAM_BYTES);
   endfunction

   // One request transfer. Valid is left high on return; the next call or
   // settle() decides whether it drops.
   task automatic push_item(input logic [1:0] mode, input logic [15:0] addr,
                            input logic [7:0] data, input logic [7:0] ln,
                            input logic [7:0] cl);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.address <= addr;
      req_bus.data    <= data;
      req_bus.line    <= ln;
      req_bus.column  <= cl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (mode == MODE_VRAM_WR) begin
         vram_shadow[addr[VRAM_AW-1:0]]  = data;
         vram_written[addr[VRAM_AW-1:0]] = 1'b1;
      end else if (mode == MODE_ROM_WR) begin
         rom_written[addr] = 1'b1;
      end
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   // byte write; line and column are don't-care and get random values
   task automatic write_byte(input logic [1:0] mode, input logic [15:0] addr,
                             input logic [7:0] data);
      push_item(mode, addr, data, 8'($urandom), 8'($urandom_range(0, VISIBLE_COLUMNS - 1)));
   endtask

   // VRAM write with random junk in the address bits above the RAM range
   task automatic write_vram(input logic [VRAM_AW-1:0] vaddr, input logic [7:0] data);
      logic [15:0] addr;
      addr                = 16'($urandom);
      addr[VRAM_AW-1:0]   = vaddr;
      write_byte(MODE_VRAM_WR, addr, data);
   endtask

   // Render one pixel. Any name or pattern byte the render needs that holds
   // no data yet is written first with random content; new_name forces a
   // fresh name byte of the given value.
   task automatic render_at(input logic [7:0] ln, input logic [7:0] cl,
                            input bit new_name, input logic [7:0] name_val);
      logic [VRAM_AW-1:0] name_addr;
      logic [7:0]         nm;
      logic [15:0]        src;
      bit                 from_rom;
      if (ln < VISIBLE_LINES && cl < VISIBLE_COLUMNS) begin
         name_addr = VRAM_AW'(2 + cl / 8 + (ln / 8) * 32);
         if (new_name)
            write_vram(name_addr, name_val);
         else if (!vram_written[name_addr])
            write_vram(name_addr, pick_name());
         nm = vram_shadow[name_addr];
         // red, green and blue planes sit 8, 16 and 24 bytes into the tile
         for (int plane = 1; plane <= 3; plane++) begin
            pattern_source(nm, plane * 8 + int'(ln[2:0]), from_rom, src);
            if (from_rom && !rom_written[src])
               write_byte(MODE_ROM_WR, src, 8'($urandom));
            else if (!from_rom && !vram_written[src[VRAM_AW-1:0]])
               write_vram(src[VRAM_AW-1:0], 8'($urandom));
         end
      end
      push_item(MODE_RENDER, 16'($urandom), 8'($urandom), ln, cl);
   endtask

   // Drain: wait until every render has produced its pixel, then give
   // trailing writes time to leave the pipeline (4 stages plus queue).
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // one config transfer; valid stays up so back-to-back writes need no drop
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_ROM_TILE_BASE)
         rom_base_now = val;
      else if (idx == CSR_RAM_TILE_BASE)
         ram_base_now = val;
   endtask

   // new tile bases, only with the block idle; a write to the unused index
   // rides along and must change nothing
   task automatic program_bases(input logic [7:0] rom_base, input logic [7:0] ram_base);
      settle();
      write_csr(CSR_ROM_TILE_BASE, rom_base);
      write_csr(CSR_RAM_TILE_BASE, ram_base);
      write_csr(CSR_UNUSED_INDEX, 8'($urandom));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_step();
      int         pick;
      logic [7:0] ln;
      logic [7:0] cl;
      pick = $urandom_range(0, 99);
      ln   = pick_line();
      cl   = 8'($urandom_range(0, VISIBLE_COLUMNS - 1));
      if (pick < 60) begin
         render_at(ln, cl, 1'b0, 8'h00);
      end else if (pick < 72) begin
         // a full tile row, left to right
         cl = 8'($urandom_range(0, VISIBLE_COLUMNS / 8 - 1) * 8);
         for (int k = 0; k < 8; k++) render_at(ln, cl + 8'(k), 1'b0, 8'h00);
      end else if (pick < 77) begin
         render_at(ln, cl, 1'b1, pick_name());
      end else if (pick < 85) begin
         write_byte(MODE_VRAM_WR, 16'($urandom), 8'($urandom));
      end else if (pick < 92) begin
         write_byte(MODE_ROM_WR, 16'($urandom), 8'($urandom));
      end else begin
         push_item(MODE_UNUSED, 16'($urandom), 8'($urandom), 8'($urandom), cl);
      end
   endtask

   // Result side: random back-pressure. Once, after a few hundred items, a
   // long hold lets the queue fill and the request side stall while the
   // stimulus keeps offering transfers.
   initial begin
      int run;
      int r;
      bit pressure_done;
      rsp_bus.ready = 1'b0;
      pressure_done = 1'b0;
      forever begin
         if (!pressure_done && items_sent >= 300) begin
            rsp_bus.ready <= 1'b0;
            repeat (150) @(posedge clock);
            pressure_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_bus.ready <= 1'b1;
               run = $urandom_range(1, 40);
            end else begin
               rsp_bus.ready <= 1'b0;
               if (r < 88)
                  run = $urandom_range(1, 3);
               else if (r < 98)
                  run = $urandom_range(4, 12);
               else
                  run = $urandom_range(30, 80);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int phase_end;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_VRAM_WR;
      req_bus.address = '0;
      req_bus.data    = '0;
      req_bus.line    = '0;
      req_bus.column  = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_ROM_TILE_BASE;
      csr_bus.wdata   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      program_bases(8'h00, 8'h00);
      // field extremes on writes; VRAM address wraps to its last byte
      write_byte(MODE_VRAM_WR, 16'hFFFF, 8'hFF);
      write_byte(MODE_ROM_WR, 16'hFFFF, 8'h00);
      write_byte(MODE_ROM_WR, 16'h0000, 8'hFF);
      // top-left and bottom-right visible pixels, ROM tiles at both ends
      render_at(8'd0, 8'd0, 1'b1, 8'h00);
      render_at(8'(VISIBLE_LINES - 1), 8'(VISIBLE_COLUMNS - 1), 1'b1, NAME_ROM_LIMIT - 8'd1);
      // first and last RAM tiles
      render_at(8'd7, 8'd7, 1'b1, NAME_ROM_LIMIT);
      render_at(8'd8, 8'd8, 1'b1, 8'hFF);
      // below the visible area: black pixel, coordinates echoed
      render_at(8'(VISIBLE_LINES), 8'd0, 1'b0, 8'h00);
      render_at(8'hFF, 8'(VISIBLE_COLUMNS - 1), 1'b0, 8'h00);
      // dropped mode
      push_item(MODE_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'(VISIBLE_COLUMNS - 1));
      // force bit turns a RAM name into a ROM tile
      program_bases(8'h10, 8'h00);
      render_at(8'd16, 8'd16, 1'b1, 8'hE5);
      // last bank, last tile, last row: reads the top byte of the ROM
      program_bases(8'hFF, 8'hFF);
      render_at(8'd7, 8'd100, 1'b1, 8'hFF);
      render_at(8'd7, 8'd101, 1'b0, 8'h00);

      // --- random part, one tile base setting per phase ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       program_bases(8'h00, 8'h00);
            1:       program_bases(8'hFF, 8'hFF);
            2:       program_bases(8'hE0, 8'h7C);
            3:       program_bases(8'h10, 8'h03);
            default: program_bases(8'($urandom), 8'($urandom));
         endcase
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) random_step();
      end

      // all pixels back and the pipeline quiet
      settle();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
